// ----- design/hcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared widths, request codes and control groups for the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int FREQ_BITS     = 24;
  localparam int MAX_CODE_LEN  = 63;

  localparam int WEIGHT_BITS = 32;
  localparam int REQ_W       = 2;
  localparam int SYM_W       = 8;
  localparam int FREQ_W      = 24;
  localparam int LEN_W       = 6;
  localparam int BITS_W      = 63;
  localparam int COUNT_W     = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // Control of the two-lowest tracker
  typedef struct packed {
    logic clear;
    logic take;
  } pick_ctrl_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } pick_stat_t;

  // Control of the code path accumulator
  typedef struct packed {
    logic start;
    logic step;
    logic branch;
  } acc_ctrl_t;

endpackage

// ----- design/hcb_pick2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pick2
// Shared compare/add unit: tracks the two lowest live nodes of a scan, lower
// index first on ties, and forms their saturated sum.
// ----------------------------------------------------------------------------
module hcb_pick2 #(
  parameter int NODE_BITS = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hcb_pkg::pick_ctrl_t                ctrl,
  input  logic [NODE_BITS-1:0]               in_idx,
  input  logic [hcb_pkg::WEIGHT_BITS-1:0]    in_weight,
  input  logic                               in_alive,
  output hcb_pkg::pick_stat_t                stat,
  output logic [NODE_BITS-1:0]               a_idx,
  output logic [hcb_pkg::WEIGHT_BITS-1:0]    a_weight,
  output logic [NODE_BITS-1:0]               b_idx,
  output logic [hcb_pkg::WEIGHT_BITS-1:0]    b_weight,
  output logic [hcb_pkg::WEIGHT_BITS-1:0]    sum_weight
);

  logic                             a_valid;
  logic                             b_valid;
  logic [hcb_pkg::WEIGHT_BITS:0]    sum_full;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (ctrl.take && in_alive) begin
      // strict compares keep the earlier index on equal weights
      if (!a_valid || in_weight < a_weight) begin
        b_valid  <= a_valid;
        b_idx    <= a_idx;
        b_weight <= a_weight;
        a_valid  <= 1'b1;
        a_idx    <= in_idx;
        a_weight <= in_weight;
      end else if (!b_valid || in_weight < b_weight) begin
        b_valid  <= 1'b1;
        b_idx    <= in_idx;
        b_weight <= in_weight;
      end
    end
  end

  assign stat.a_valid = a_valid;
  assign stat.b_valid = b_valid;

  assign sum_full   = {1'b0, a_weight} + {1'b0, b_weight};
  assign sum_weight = sum_full[hcb_pkg::WEIGHT_BITS] ? '1
                                                     : sum_full[hcb_pkg::WEIGHT_BITS-1:0];

endmodule

// ----- design/hcb_code_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_code_acc
// Collects branch bits while walking from a leaf to the root, clamps the
// length and right-aligns the code.
// ----------------------------------------------------------------------------
module hcb_code_acc #(
  parameter int DEPTH_BITS   = 9,
  parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN
) (
  input  logic                           clk,
  input  hcb_pkg::acc_ctrl_t             ctrl,
  output logic [hcb_pkg::LEN_W-1:0]      len,
  output logic [hcb_pkg::BITS_W-1:0]     bits
);

  localparam int CW = (DEPTH_BITS > hcb_pkg::LEN_W) ? DEPTH_BITS : hcb_pkg::LEN_W + 1;

  logic [DEPTH_BITS-1:0]     depth;
  logic [MAX_CODE_LEN-1:0]   path;
  logic [CW-1:0]             depth_x;
  logic [hcb_pkg::LEN_W-1:0] shamt;

  // branch nearest the root ends up in the top bit of path
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      depth <= '0;
      path  <= '0;
    end else if (ctrl.step) begin
      depth <= depth + 1'b1;
      path  <= {ctrl.branch, path[MAX_CODE_LEN-1:1]};
    end
  end

  always_comb begin
    depth_x = CW'(depth);
    len     = (depth_x < CW'(MAX_CODE_LEN)) ? hcb_pkg::LEN_W'(depth_x)
                                            : hcb_pkg::LEN_W'(MAX_CODE_LEN);
    shamt   = hcb_pkg::LEN_W'(MAX_CODE_LEN) - len;
    bits    = hcb_pkg::BITS_W'(path) >> shamt;
  end

endmodule

// ----- design/huffman_code_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder
// Huffman code construction for a byte alphabet with load, build and query.
// ----------------------------------------------------------------------------
// Handles one request at a time. A load gives no result beat; a query gives
// one result beat. A build first seeds the leaves, then for each merge makes
// one scan of all nodes created so far through the single read port of the
// node memory, then selects each loaded symbol in turn and walks from it to
// the root through the parent memory.
// Codes longer than MAX_CODE_LEN keep their branches nearest the root.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int ALPHABET_SIZE = hcb_pkg::ALPHABET_SIZE,
  parameter int FREQ_BITS     = hcb_pkg::FREQ_BITS,
  parameter int MAX_CODE_LEN  = hcb_pkg::MAX_CODE_LEN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hcb_pkg::REQ_W-1:0]      req_type,
  input  logic [hcb_pkg::SYM_W-1:0]      symbol,
  input  logic [hcb_pkg::FREQ_W-1:0]     frequency,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           present,
  output logic [hcb_pkg::LEN_W-1:0]      code_length,
  output logic [hcb_pkg::BITS_W-1:0]     code_bits,
  output logic [hcb_pkg::COUNT_W-1:0]    symbol_count
);

  localparam int NODE_COUNT = 2 * ALPHABET_SIZE - 1;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int SYM_BITS   = $clog2(ALPHABET_SIZE);
  localparam int SCNT_BITS  = $clog2(ALPHABET_SIZE + 1);
  localparam int WB         = hcb_pkg::WEIGHT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QOUT, ST_INIT_RD, ST_INIT_WR, ST_SCAN0, ST_SCAN,
    ST_MRG0, ST_MRG1, ST_MRG2, ST_CG0, ST_CG_SEL, ST_CG_RD, ST_CG_STEP,
    ST_CG_WR, ST_BOUT
  } state_t;

  state_t state;

  // storage
  logic [FREQ_BITS-1:0]        freq_mem  [ALPHABET_SIZE];
  logic [WB:0]                 node_mem  [NODE_COUNT];
  logic [NODE_BITS:0]          par_mem   [NODE_COUNT];
  logic [hcb_pkg::LEN_W-1:0]   clen_mem  [ALPHABET_SIZE];
  logic [hcb_pkg::BITS_W-1:0]  cbits_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0]    loaded_flag;
  logic [ALPHABET_SIZE-1:0]    code_valid;

  logic [FREQ_BITS-1:0]        freq_rd;
  logic [WB:0]                 node_rd;
  logic [NODE_BITS:0]          par_rd;
  logic [hcb_pkg::LEN_W-1:0]   clen_rd;
  logic [hcb_pkg::BITS_W-1:0]  cbits_rd;

  // sequencer registers
  logic [SCNT_BITS-1:0]        sidx;
  logic [hcb_pkg::COUNT_W-1:0] count;
  logic [NODE_BITS-1:0]        root;
  logic                        root_valid;
  logic [NODE_BITS-1:0]        next_node;
  logic [NODE_BITS-1:0]        scan_idx;
  logic                        rd_pend;
  logic [NODE_BITS-1:0]        pend_idx;
  logic [NODE_BITS-1:0]        cur;
  logic                        qok;

  // handshake and ports
  logic                        in_acc;
  logic                        out_free;
  logic                        sym_ok;
  logic [SYM_BITS-1:0]         sym_idx;
  logic [SYM_BITS-1:0]         s_idx;
  logic                        s_last;
  logic                        s_end;

  logic                        freq_we;
  logic                        node_we;
  logic [NODE_BITS-1:0]        node_waddr;
  logic [WB:0]                 node_wdata;
  logic                        node_re;
  logic                        par_we;
  logic [NODE_BITS-1:0]        par_waddr;
  logic [NODE_BITS:0]          par_wdata;
  logic                        par_re;

  hcb_pkg::pick_ctrl_t         pick_ctrl;
  hcb_pkg::pick_stat_t         pick_stat;
  logic [NODE_BITS-1:0]        a_idx;
  logic [NODE_BITS-1:0]        b_idx;
  logic [WB-1:0]               a_weight;
  logic [WB-1:0]               b_weight;
  logic [WB-1:0]               sum_weight;

  hcb_pkg::acc_ctrl_t          acc_ctrl;
  logic [hcb_pkg::LEN_W-1:0]   acc_len;
  logic [hcb_pkg::BITS_W-1:0]  acc_bits;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sym_ok   = ({1'b0, symbol} < (hcb_pkg::SYM_W + 1)'(ALPHABET_SIZE));
  assign sym_idx  = SYM_BITS'(symbol);
  assign s_idx    = sidx[SYM_BITS-1:0];
  assign s_last   = (sidx == SCNT_BITS'(ALPHABET_SIZE - 1));
  assign s_end    = (sidx == SCNT_BITS'(ALPHABET_SIZE));

  hcb_pick2 #(
    .NODE_BITS(NODE_BITS)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pick_ctrl),
    .in_idx     (pend_idx),
    .in_weight  (node_rd[WB-1:0]),
    .in_alive   (node_rd[WB]),
    .stat       (pick_stat),
    .a_idx      (a_idx),
    .a_weight   (a_weight),
    .b_idx      (b_idx),
    .b_weight   (b_weight),
    .sum_weight (sum_weight)
  );

  hcb_code_acc #(
    .DEPTH_BITS  (NODE_BITS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_acc (
    .clk (clk),
    .ctrl(acc_ctrl),
    .len (acc_len),
    .bits(acc_bits)
  );

  // memory port steering
  always_comb begin
    freq_we    = in_acc && (req_type == hcb_pkg::REQ_LOAD) && sym_ok;
    node_we    = 1'b0;
    node_waddr = a_idx;
    node_wdata = {1'b0, a_weight};
    par_we     = 1'b0;
    par_waddr  = a_idx;
    par_wdata  = {next_node, 1'b0};
    unique case (state)
      ST_INIT_WR: begin
        node_we    = 1'b1;
        node_waddr = NODE_BITS'(sidx);
        node_wdata = {loaded_flag[s_idx], WB'(freq_rd)};
      end
      ST_MRG0: begin
        node_we = 1'b1;
        par_we  = 1'b1;
      end
      ST_MRG1: begin
        node_we    = 1'b1;
        node_waddr = b_idx;
        node_wdata = {1'b0, b_weight};
        par_we     = 1'b1;
        par_waddr  = b_idx;
        par_wdata  = {next_node, 1'b1};
      end
      ST_MRG2: begin
        node_we    = 1'b1;
        node_waddr = next_node;
        node_wdata = {1'b1, sum_weight};
      end
      default: begin
      end
    endcase
    node_re         = (state == ST_SCAN) && (scan_idx != next_node);
    par_re          = (state == ST_CG_RD) && (cur != root);
    pick_ctrl.clear = (state == ST_SCAN0);
    pick_ctrl.take  = (state == ST_SCAN) && rd_pend;
    acc_ctrl.start  = (state == ST_CG_SEL) && !s_end && loaded_flag[s_idx];
    acc_ctrl.step   = (state == ST_CG_STEP);
    acc_ctrl.branch = par_rd[0];
  end

  // memories
  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[sym_idx] <= FREQ_BITS'(frequency);
    end
    if (state == ST_INIT_RD) begin
      freq_rd <= freq_mem[s_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd <= node_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (par_re) begin
      par_rd <= par_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CG_WR) begin
      clen_mem[s_idx]  <= acc_len;
      cbits_mem[s_idx] <= acc_bits;
    end
    if (in_acc) begin
      clen_rd  <= clen_mem[sym_idx];
      cbits_rd <= cbits_mem[sym_idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      loaded_flag <= '0;
      code_valid  <= '0;
      out_valid   <= 1'b0;
      root_valid  <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      // the output states load the next beat themselves
      if (out_valid && out_ready && (state != ST_QOUT) && (state != ST_BOUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (hcb_pkg::req_t'(req_type))
              hcb_pkg::REQ_LOAD: begin
                if (sym_ok) begin
                  loaded_flag[sym_idx] <= 1'b1;
                end
              end
              hcb_pkg::REQ_BUILD: begin
                code_valid <= '0;
                sidx       <= '0;
                count      <= '0;
                root_valid <= 1'b0;
                state      <= ST_INIT_RD;
              end
              hcb_pkg::REQ_QUERY: begin
                qok   <= sym_ok && code_valid[sym_idx];
                state <= ST_QOUT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_QOUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            present      <= qok;
            code_length  <= qok ? clen_rd : '0;
            code_bits    <= qok ? cbits_rd : '0;
            symbol_count <= '0;
            state        <= ST_IDLE;
          end
        end
        ST_INIT_RD: begin
          state <= ST_INIT_WR;
        end
        ST_INIT_WR: begin
          if (loaded_flag[s_idx]) begin
            count      <= count + 1'b1;
            root       <= NODE_BITS'(sidx);
            root_valid <= 1'b1;
          end
          sidx <= sidx + 1'b1;
          if (s_last) begin
            next_node <= NODE_BITS'(ALPHABET_SIZE);
            state     <= ST_SCAN0;
          end else begin
            state <= ST_INIT_RD;
          end
        end
        ST_SCAN0: begin
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // issue one read a cycle, fold in the previous beat
          rd_pend  <= node_re;
          pend_idx <= scan_idx;
          if (node_re) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!rd_pend) begin
            state <= pick_stat.b_valid ? ST_MRG0 : ST_CG0;
          end
        end
        ST_MRG0: begin
          state <= ST_MRG1;
        end
        ST_MRG1: begin
          state <= ST_MRG2;
        end
        ST_MRG2: begin
          root       <= next_node;
          root_valid <= 1'b1;
          next_node  <= next_node + 1'b1;
          if (next_node == NODE_BITS'(NODE_COUNT - 1)) begin
            state <= ST_CG0;
          end else begin
            state <= ST_SCAN0;
          end
        end
        ST_CG0: begin
          sidx  <= '0;
          state <= root_valid ? ST_CG_SEL : ST_BOUT;
        end
        ST_CG_SEL: begin
          if (s_end) begin
            state <= ST_BOUT;
          end else if (loaded_flag[s_idx]) begin
            cur   <= NODE_BITS'(sidx);
            state <= ST_CG_RD;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        ST_CG_RD: begin
          state <= (cur == root) ? ST_CG_WR : ST_CG_STEP;
        end
        ST_CG_STEP: begin
          cur   <= par_rd[NODE_BITS:1];
          state <= ST_CG_RD;
        end
        ST_CG_WR: begin
          code_valid[s_idx] <= 1'b1;
          sidx              <= sidx + 1'b1;
          state             <= ST_CG_SEL;
        end
        ST_BOUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            present      <= 1'b0;
            code_length  <= '0;
            code_bits    <= '0;
            symbol_count <= count;
            loaded_flag  <= '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_build_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == hcb_pkg::REQ_BUILD |=> !in_ready)
    else $error("build accepted but block still ready");

  a_len_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && present |-> code_length <= hcb_pkg::LEN_W'(MAX_CODE_LEN))
    else $error("code length above limit");

  a_build_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && symbol_count != '0 |-> !present && code_length == '0)
    else $error("build beat carries code fields");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol_count <= hcb_pkg::COUNT_W'(ALPHABET_SIZE))
    else $error("symbol count above alphabet size");
`endif

endmodule
